// ----- hw/rtl/hsvrgb_pkg.sv -----
`default_nettype none

package hsvrgb_pkg;

    // Port widths of the conversion.
    localparam int HUE_W = 24;
    localparam int SV_W  = 16;
    localparam int CH_W  = 8;

    // One in Q3.12 and the clamped unit range it bounds.
    localparam logic [12:0] UNIT_ONE = 13'd4096;

    // A full turn is 23040 = 45 * 512 hue units. The hue above its low nine
    // bits is reduced modulo 45; 16425 = 365 * 45 lifts it to a positive range.
    localparam logic [15:0] WRAP_OFFSET = 16'd16425;
    localparam logic [10:0] RECIP_45    = 11'd1456;
    localparam logic [5:0]  HUE_BLOCKS  = 6'd45;

    // One sextant of the wrapped hue, 60 degrees in 1/64 degree units.
    localparam logic [11:0] SEXTANT_SPAN = 12'd3840;

    // Reciprocal of 15 in Q15, exact for dividends up to 3825.
    localparam logic [11:0] RECIP_15 = 12'd2185;

    typedef logic [2:0]  t_sextant;
    typedef logic [12:0] t_unit;
    typedef logic [24:0] t_chroma;
    typedef logic [11:0] t_weight;
    typedef logic [35:0] t_term;
    typedef logic [11:0] t_scaled;

    // Front end to mixer: sextant, weight of x, chroma and value.
    typedef struct packed {
        logic     valid;
        t_sextant sextant;
        t_weight  k;
        t_chroma  c;
        t_unit    v;
    } t_front;

    // Mixer to divider: each channel times 255, already shifted down by 2^32.
    typedef struct packed {
        logic    valid;
        t_scaled d_red;
        t_scaled d_green;
        t_scaled d_blue;
    } t_mix;

    // Which term a channel takes in the current sextant.
    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_C,
        SEL_X
    } t_sel;

    // Start of each sextant on the wrapped hue scale.
    function automatic logic [14:0] sextant_base(input t_sextant sx);
        logic [14:0] base;
        unique case (sx)
            3'd0:    base = 15'd0;
            3'd1:    base = 15'd3840;
            3'd2:    base = 15'd7680;
            3'd3:    base = 15'd11520;
            3'd4:    base = 15'd15360;
            3'd5:    base = 15'd19200;
            default: base = 15'd0;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hsvrgb_front.sv -----
`default_nettype none

// Four stages: clamp and lift, reciprocal estimate and chroma product,
// remainder correction, sextant and weight.
module hsvrgb_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [hsvrgb_pkg::HUE_W-1:0]  i_hue,
    input  wire logic [hsvrgb_pkg::SV_W-1:0]   i_saturation,
    input  wire logic [hsvrgb_pkg::SV_W-1:0]   i_brightness,
    output hsvrgb_pkg::t_front                 o_front
);

    function automatic hsvrgb_pkg::t_unit clamp_unit(input logic [15:0] q);
        hsvrgb_pkg::t_unit r;
        if (q[15]) begin
            r = '0;
        end else if (q[14:0] > 15'(hsvrgb_pkg::UNIT_ONE)) begin
            r = hsvrgb_pkg::UNIT_ONE;
        end else begin
            r = q[12:0];
        end
        return r;
    endfunction

    // Stage 1
    logic                r_val1;
    logic [15:0]         r_u1;
    logic [8:0]          r_lo1;
    hsvrgb_pkg::t_unit   r_s1;
    hsvrgb_pkg::t_unit   r_v1;
    logic [15:0]         n_u1;

    assign n_u1 = {i_hue[23], i_hue[23:9]} + hsvrgb_pkg::WRAP_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val1 <= 1'b0;
        end else begin
            r_val1 <= i_valid;
        end
        r_u1  <= n_u1;
        r_lo1 <= i_hue[8:0];
        r_s1  <= clamp_unit(i_saturation);
        r_v1  <= clamp_unit(i_brightness);
    end

    // Stage 2
    logic                  r_val2;
    logic [15:0]           r_u2;
    logic [8:0]            r_lo2;
    logic [9:0]            r_q2;
    hsvrgb_pkg::t_chroma   r_c2;
    hsvrgb_pkg::t_unit     r_v2;
    logic [25:0]           q_prod;
    logic [25:0]           c_prod;

    assign q_prod = 26'(r_u1) * 26'(hsvrgb_pkg::RECIP_45);
    assign c_prod = 26'(r_v1) * 26'(r_s1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val2 <= 1'b0;
        end else begin
            r_val2 <= r_val1;
        end
        r_u2  <= r_u1;
        r_lo2 <= r_lo1;
        r_q2  <= q_prod[25:16];
        r_c2  <= c_prod[24:0];
        r_v2  <= r_v1;
    end

    // Stage 3: the estimate is exact or one short, so one subtraction fixes it.
    logic                  r_val3;
    logic [5:0]            r_t3;
    logic [8:0]            r_lo3;
    hsvrgb_pkg::t_chroma   r_c3;
    hsvrgb_pkg::t_unit     r_v3;
    logic [15:0]           rem;
    logic [6:0]            rem_lo;
    logic [5:0]            n_t3;

    assign rem    = r_u2 - 16'(16'(r_q2) * 16'(hsvrgb_pkg::HUE_BLOCKS));
    assign rem_lo = rem[6:0];

    always_comb begin
        if (rem_lo >= 7'(hsvrgb_pkg::HUE_BLOCKS)) begin
            n_t3 = 6'(rem_lo - 7'(hsvrgb_pkg::HUE_BLOCKS));
        end else begin
            n_t3 = rem_lo[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val3 <= 1'b0;
        end else begin
            r_val3 <= r_val2;
        end
        r_t3  <= n_t3;
        r_lo3 <= r_lo2;
        r_c3  <= r_c2;
        r_v3  <= r_v2;
    end

    // Stage 4
    logic                   r_val4;
    hsvrgb_pkg::t_sextant   r_sx4;
    hsvrgb_pkg::t_weight    r_k4;
    hsvrgb_pkg::t_chroma    r_c4;
    hsvrgb_pkg::t_unit      r_v4;
    logic [14:0]            hw;
    hsvrgb_pkg::t_sextant   n_sx4;
    hsvrgb_pkg::t_weight    f;
    hsvrgb_pkg::t_weight    n_k4;

    assign hw = {r_t3, r_lo3};

    always_comb begin
        if (hw >= hsvrgb_pkg::sextant_base(3'd5)) begin
            n_sx4 = 3'd5;
        end else if (hw >= hsvrgb_pkg::sextant_base(3'd4)) begin
            n_sx4 = 3'd4;
        end else if (hw >= hsvrgb_pkg::sextant_base(3'd3)) begin
            n_sx4 = 3'd3;
        end else if (hw >= hsvrgb_pkg::sextant_base(3'd2)) begin
            n_sx4 = 3'd2;
        end else if (hw >= hsvrgb_pkg::sextant_base(3'd1)) begin
            n_sx4 = 3'd1;
        end else begin
            n_sx4 = 3'd0;
        end
        f = 12'(hw - hsvrgb_pkg::sextant_base(n_sx4));
        if (n_sx4[0]) begin
            n_k4 = hsvrgb_pkg::SEXTANT_SPAN - f;
        end else begin
            n_k4 = f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val4 <= 1'b0;
        end else begin
            r_val4 <= r_val3;
        end
        r_sx4 <= n_sx4;
        r_k4  <= n_k4;
        r_c4  <= r_c3;
        r_v4  <= r_v3;
    end

    assign o_front.valid   = r_val4;
    assign o_front.sextant = r_sx4;
    assign o_front.k       = r_k4;
    assign o_front.c       = r_c4;
    assign o_front.v       = r_v4;

endmodule

`default_nettype wire

// ----- hw/rtl/hsvrgb_mix.sv -----
`default_nettype none

// Two stages: the three terms c*3840, c*k and m*3840, then the sextant
// permutation, the sum with m and the scaling by 255 / 2^32.
module hsvrgb_mix (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  hsvrgb_pkg::t_front i_front,
    output hsvrgb_pkg::t_mix   o_mix
);

    function automatic hsvrgb_pkg::t_scaled scale_channel(
        input hsvrgb_pkg::t_sel  sel,
        input hsvrgb_pkg::t_term xs,
        input hsvrgb_pkg::t_term cs,
        input hsvrgb_pkg::t_term ms
    );
        hsvrgb_pkg::t_term p;
        hsvrgb_pkg::t_term sum;
        logic [43:0]       t;
        case (sel)
            hsvrgb_pkg::SEL_C: p = cs;
            hsvrgb_pkg::SEL_X: p = xs;
            default:           p = '0;
        endcase
        sum = p + ms;
        t   = (44'(sum) << 8) - 44'(sum);
        return t[43:32];
    endfunction

    // Stage 5
    logic                   r_val5;
    hsvrgb_pkg::t_sextant   r_sx5;
    hsvrgb_pkg::t_term      r_xs5;
    hsvrgb_pkg::t_term      r_cs5;
    hsvrgb_pkg::t_term      r_ms5;
    logic [36:0]            x_prod;
    logic [24:0]            vm;

    assign x_prod = 37'(i_front.c) * 37'(i_front.k);
    assign vm     = {i_front.v, 12'd0} - i_front.c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val5 <= 1'b0;
        end else begin
            r_val5 <= i_front.valid;
        end
        r_sx5 <= i_front.sextant;
        r_xs5 <= x_prod[35:0];
        r_cs5 <= (36'(i_front.c) << 12) - (36'(i_front.c) << 8);
        r_ms5 <= (36'(vm) << 12) - (36'(vm) << 8);
    end

    // Stage 6
    logic                   r_val6;
    hsvrgb_pkg::t_scaled    r_dr6;
    hsvrgb_pkg::t_scaled    r_dg6;
    hsvrgb_pkg::t_scaled    r_db6;
    hsvrgb_pkg::t_sel       sel_r;
    hsvrgb_pkg::t_sel       sel_g;
    hsvrgb_pkg::t_sel       sel_b;

    always_comb begin
        unique case (r_sx5)
            3'd0: begin
                sel_r = hsvrgb_pkg::SEL_C;
                sel_g = hsvrgb_pkg::SEL_X;
                sel_b = hsvrgb_pkg::SEL_ZERO;
            end
            3'd1: begin
                sel_r = hsvrgb_pkg::SEL_X;
                sel_g = hsvrgb_pkg::SEL_C;
                sel_b = hsvrgb_pkg::SEL_ZERO;
            end
            3'd2: begin
                sel_r = hsvrgb_pkg::SEL_ZERO;
                sel_g = hsvrgb_pkg::SEL_C;
                sel_b = hsvrgb_pkg::SEL_X;
            end
            3'd3: begin
                sel_r = hsvrgb_pkg::SEL_ZERO;
                sel_g = hsvrgb_pkg::SEL_X;
                sel_b = hsvrgb_pkg::SEL_C;
            end
            3'd4: begin
                sel_r = hsvrgb_pkg::SEL_X;
                sel_g = hsvrgb_pkg::SEL_ZERO;
                sel_b = hsvrgb_pkg::SEL_C;
            end
            default: begin
                sel_r = hsvrgb_pkg::SEL_C;
                sel_g = hsvrgb_pkg::SEL_ZERO;
                sel_b = hsvrgb_pkg::SEL_X;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val6 <= 1'b0;
        end else begin
            r_val6 <= r_val5;
        end
        r_dr6 <= scale_channel(sel_r, r_xs5, r_cs5, r_ms5);
        r_dg6 <= scale_channel(sel_g, r_xs5, r_cs5, r_ms5);
        r_db6 <= scale_channel(sel_b, r_xs5, r_cs5, r_ms5);
    end

    assign o_mix.valid   = r_val6;
    assign o_mix.d_red   = r_dr6;
    assign o_mix.d_green = r_dg6;
    assign o_mix.d_blue  = r_db6;

endmodule

`default_nettype wire

// ----- hw/rtl/hsvrgb_div15.sv -----
`default_nettype none

// Final stage: each scaled channel divided by 15 through a Q15 reciprocal,
// into the output registers.
module hsvrgb_div15 (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  hsvrgb_pkg::t_mix                 i_mix,
    output logic                             o_valid,
    output logic [hsvrgb_pkg::CH_W-1:0]      o_red,
    output logic [hsvrgb_pkg::CH_W-1:0]      o_green,
    output logic [hsvrgb_pkg::CH_W-1:0]      o_blue
);

    function automatic logic [7:0] div15(input hsvrgb_pkg::t_scaled d);
        logic [23:0] prod;
        prod = 24'(d) * 24'(hsvrgb_pkg::RECIP_15);
        return prod[22:15];
    endfunction

    logic       r_val7;
    logic [7:0] r_red7;
    logic [7:0] r_green7;
    logic [7:0] r_blue7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val7 <= 1'b0;
        end else begin
            r_val7 <= i_mix.valid;
        end
        r_red7   <= div15(i_mix.d_red);
        r_green7 <= div15(i_mix.d_green);
        r_blue7  <= div15(i_mix.d_blue);
    end

    assign o_valid = r_val7;
    assign o_red   = r_red7;
    assign o_green = r_green7;
    assign o_blue  = r_blue7;

endmodule

`default_nettype wire

// ----- hw/rtl/hsv_to_rgb_pixel_core.sv -----
// HSV to 8-bit RGB pixel converter.
// Input channel: a transaction is taken at each rising edge with start high and
// busy low. Hue is signed in 1/64 degree and wraps modulo 360 degrees;
// saturation and brightness are signed Q3.12 and are clamped to the range 0..1.
// Output channel: o_valid marks o_red, o_green and o_blue for exactly one cycle;
// the receiver has no way to hold results back, and none is needed.
// Throughput: one transaction per clock; busy is always low because every
// stage advances each cycle. The pipeline has seven register stages: hue
// lifting and clamping, reciprocal estimate of the hue modulo 45 together
// with the chroma product, remainder correction, sextant and weight, the
// three products, the permutation sum scaled by 255, and a reciprocal
// division by 15.
// Reset (synchronous, active low) clears only the valid bits of every stage,
// so all transactions in flight are dropped and no result appears until new
// transactions are taken.
`default_nettype none

module hsv_to_rgb_pixel_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [hsvrgb_pkg::HUE_W-1:0] i_hue,
    input  wire logic signed [hsvrgb_pkg::SV_W-1:0]  i_saturation,
    input  wire logic signed [hsvrgb_pkg::SV_W-1:0]  i_brightness,
    output logic                                    o_valid,
    output logic [hsvrgb_pkg::CH_W-1:0]             o_red,
    output logic [hsvrgb_pkg::CH_W-1:0]             o_green,
    output logic [hsvrgb_pkg::CH_W-1:0]             o_blue
);

    hsvrgb_pkg::t_front front;
    hsvrgb_pkg::t_mix   mix;
    logic               accept;

    // Every stage moves forward each cycle, so the block never refuses work.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    hsvrgb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_front      (front)
    );

    hsvrgb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_front (front),
        .o_mix   (mix)
    );

    hsvrgb_div15 u_div15 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mix   (mix),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    // Every accepted transaction yields its result once it has passed every stage.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##7 o_valid)
        else $error("accepted transaction produced no result after seven cycles");

    // No result appears without a matching accepted transaction.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 7))
        else $error("result strobe without a matching transaction");

    // A brightness at or below zero clamps to black whatever the hue.
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_brightness[15] || (i_brightness == 16'sd0), 7))
        |-> (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0))
        else $error("zero brightness did not give black");

endmodule

`default_nettype wire
